>>> rtl/intel_hex_record_encoder_macros.svh
// Assertion macros for the Intel HEX record encoder checker.
// No dependencies; included by the checker file only.
`ifndef INTEL_HEX_RECORD_ENCODER_MACROS_SVH
`define INTEL_HEX_RECORD_ENCODER_MACROS_SVH

// same-cycle implication, off during reset
`define IHEX_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ihex check failed");

// next-cycle implication, off during reset
`define IHEX_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ihex check failed");

// next-cycle implication, live during reset
`define IHEX_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("ihex check failed");

`endif

>>> rtl/ihex_pkg.sv
// Shared types, codes and helpers of the Intel HEX record encoder.
// No dependencies; used by ihex_useq, ihex_dp and the top level.
package ihex_pkg;

  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_ADDR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ADD_END    = 2'd1;

  // character source of one microcode step
  typedef enum logic [3:0] {
    SRC_LIT,
    SRC_LEN_H,
    SRC_LEN_L,
    SRC_AH_H,
    SRC_AH_L,
    SRC_AL_H,
    SRC_AL_L,
    SRC_DAT_H,
    SRC_DAT_L,
    SRC_CK_H,
    SRC_CK_L
  } src_e_t;

  // checksum accumulate operand
  typedef enum logic [1:0] {
    ADD_NONE,
    ADD_LEN,
    ADD_AH,
    ADD_AL
  } add_e_t;

  // sequencer branch kind
  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_LOOP,
    JMP_EOF,
    JMP_END
  } jmp_e_t;

  typedef struct packed {
    src_e_t     src;
    logic [6:0] lit;
    add_e_t     add;
    logic       add_dat;
    jmp_e_t     jmp;
  } ucw_t;

  typedef struct packed {
    logic busy;
    logic fin;
    ucw_t uw;
  } seq_st_t;

  typedef struct packed {
    logic                 vld;
    logic [CFG_IDX_W-1:0] idx;
    logic [15:0]          data;
  } cfg_wr_t;

  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [6:0] c;
    if (nib < 4'd10) begin
      c = 7'h30 + {3'b000, nib};
    end else begin
      c = 7'h37 + {3'b000, nib};
    end
    return c;
  endfunction

endpackage

>>> rtl/ihex_useq.sv
// Microcode sequencer: step counter, control ROM and branch logic.
// Depends on ihex_pkg.
module ihex_useq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              adv,
  input  logic              loop_more,
  input  logic              eof_go,
  output ihex_pkg::seq_st_t seq_st
);
  import ihex_pkg::*;

  localparam logic [4:0] PC_DAT_H = 5'd9;

  // one word per emitted character
  function automatic ucw_t rom(input logic [4:0] pc);
    ucw_t w;
    w = '{SRC_LIT, 7'h00, ADD_NONE, 1'b0, JMP_NEXT};
    case (pc)
      5'd0:  w = '{SRC_LIT,   7'h3A, ADD_NONE, 1'b0, JMP_NEXT};
      5'd1:  w = '{SRC_LEN_H, 7'h00, ADD_LEN,  1'b0, JMP_NEXT};
      5'd2:  w = '{SRC_LEN_L, 7'h00, ADD_NONE, 1'b0, JMP_NEXT};
      5'd3:  w = '{SRC_AH_H,  7'h00, ADD_AH,   1'b0, JMP_NEXT};
      5'd4:  w = '{SRC_AH_L,  7'h00, ADD_NONE, 1'b0, JMP_NEXT};
      5'd5:  w = '{SRC_AL_H,  7'h00, ADD_AL,   1'b0, JMP_NEXT};
      5'd6:  w = '{SRC_AL_L,  7'h00, ADD_NONE, 1'b0, JMP_NEXT};
      5'd7:  w = '{SRC_LIT,   7'h30, ADD_NONE, 1'b0, JMP_NEXT};
      5'd8:  w = '{SRC_LIT,   7'h30, ADD_NONE, 1'b0, JMP_NEXT};
      5'd9:  w = '{SRC_DAT_H, 7'h00, ADD_NONE, 1'b1, JMP_NEXT};
      5'd10: w = '{SRC_DAT_L, 7'h00, ADD_NONE, 1'b0, JMP_LOOP};
      5'd11: w = '{SRC_CK_H,  7'h00, ADD_NONE, 1'b0, JMP_NEXT};
      5'd12: w = '{SRC_CK_L,  7'h00, ADD_NONE, 1'b0, JMP_NEXT};
      5'd13: w = '{SRC_LIT,   7'h0A, ADD_NONE, 1'b0, JMP_EOF};
      // end-of-file record
      5'd14: w = '{SRC_LIT,   7'h3A, ADD_NONE, 1'b0, JMP_NEXT};
      5'd15, 5'd16, 5'd17, 5'd18, 5'd19, 5'd20, 5'd21:
             w = '{SRC_LIT,   7'h30, ADD_NONE, 1'b0, JMP_NEXT};
      5'd22: w = '{SRC_LIT,   7'h31, ADD_NONE, 1'b0, JMP_NEXT};
      5'd23: w = '{SRC_LIT,   7'h46, ADD_NONE, 1'b0, JMP_NEXT};
      5'd24: w = '{SRC_LIT,   7'h46, ADD_NONE, 1'b0, JMP_NEXT};
      5'd25: w = '{SRC_LIT,   7'h0A, ADD_NONE, 1'b0, JMP_END};
      default: w = '{SRC_LIT, 7'h00, ADD_NONE, 1'b0, JMP_END};
    endcase
    return w;
  endfunction

  logic [4:0] pc_r, pc_nxt;
  logic       busy_r, busy_nxt;
  ucw_t       uw;
  logic       fin;

  assign uw  = rom(pc_r);
  assign fin = busy_r && ((uw.jmp == JMP_END) || ((uw.jmp == JMP_EOF) && !eof_go));

  always_comb begin
    pc_nxt   = pc_r;
    busy_nxt = busy_r;
    if (start) begin
      busy_nxt = 1'b1;
      pc_nxt   = '0;
    end else if (adv) begin
      if (fin) begin
        busy_nxt = 1'b0;
        pc_nxt   = '0;
      end else if ((uw.jmp == JMP_LOOP) && loop_more) begin
        pc_nxt = PC_DAT_H;
      end else begin
        pc_nxt = pc_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= '0;
      busy_r <= 1'b0;
    end else begin
      pc_r   <= pc_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign seq_st = '{busy: busy_r, fin: fin, uw: uw};

endmodule

>>> rtl/ihex_dp.sv
// Datapath: byte buffer, fill count, record address, checksum, char mux.
// Depends on ihex_pkg.
module ihex_dp #(
  parameter int RECORD_BYTES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_acc,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  input  ihex_pkg::cfg_wr_t cfg,
  input  logic              adv,
  input  ihex_pkg::seq_st_t seq_st,
  output logic              rec_due,
  output logic              loop_more,
  output logic              eof_go,
  output logic [6:0]        ch
);
  import ihex_pkg::*;

  localparam int CNT_W = $clog2(RECORD_BYTES + 1);
  localparam int IDX_W = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;

  logic [7:0]       bytes_r [RECORD_BYTES];
  logic [CNT_W-1:0] fill_r, fill_nxt, fill_inc;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]       sum_r, sum_nxt, addv;
  logic [15:0]      addr_r, addr_nxt;
  logic [15:0]      start_r, start_nxt;
  logic             add_end_r, add_end_nxt;
  logic             last_r, last_nxt;
  logic [7:0]       dat, len8, ck;
  logic [3:0]       nib;
  logic             cfg_start, cfg_end;

  assign fill_inc  = fill_r + 1'b1;
  assign rec_due   = in_last || (fill_inc == CNT_W'(RECORD_BYTES));
  assign loop_more = (CNT_W'(idx_r) + 1'b1) != fill_r;
  assign eof_go    = last_r && add_end_r;
  assign dat       = bytes_r[idx_r];
  assign len8      = 8'(fill_r);
  assign ck        = 8'd0 - sum_r;
  assign cfg_start = cfg.vld && (cfg.idx == REG_START_ADDR);
  assign cfg_end   = cfg.vld && (cfg.idx == REG_ADD_END);

  always_comb begin
    case (seq_st.uw.src)
      SRC_LEN_H: nib = len8[7:4];
      SRC_LEN_L: nib = len8[3:0];
      SRC_AH_H:  nib = addr_r[15:12];
      SRC_AH_L:  nib = addr_r[11:8];
      SRC_AL_H:  nib = addr_r[7:4];
      SRC_AL_L:  nib = addr_r[3:0];
      SRC_DAT_H: nib = dat[7:4];
      SRC_DAT_L: nib = dat[3:0];
      SRC_CK_H:  nib = ck[7:4];
      SRC_CK_L:  nib = ck[3:0];
      default:   nib = 4'h0;
    endcase
    ch = (seq_st.uw.src == SRC_LIT) ? seq_st.uw.lit : hex_char(nib);
  end

  always_comb begin
    case (seq_st.uw.add)
      ADD_LEN: addv = len8;
      ADD_AH:  addv = addr_r[15:8];
      ADD_AL:  addv = addr_r[7:0];
      default: addv = 8'h00;
    endcase
    if (seq_st.uw.add_dat) begin
      addv = dat;
    end
  end

  always_comb begin
    fill_nxt    = fill_r;
    idx_nxt     = idx_r;
    sum_nxt     = sum_r;
    addr_nxt    = addr_r;
    start_nxt   = start_r;
    add_end_nxt = add_end_r;
    last_nxt    = last_r;
    if (in_acc) begin
      fill_nxt = fill_inc;
      last_nxt = in_last;
    end
    if (adv) begin
      sum_nxt = sum_r + addv;
      if (seq_st.uw.src == SRC_DAT_L) begin
        idx_nxt = loop_more ? (idx_r + 1'b1) : '0;
      end
      if (seq_st.fin) begin
        fill_nxt = '0;
        idx_nxt  = '0;
        sum_nxt  = 8'h00;
        addr_nxt = last_r ? start_r : (addr_r + 16'(RECORD_BYTES));
      end
    end
    if (cfg_start) begin
      start_nxt = cfg.data;
      addr_nxt  = cfg.data;
    end
    if (cfg_end) begin
      add_end_nxt = cfg.data[0];
    end
  end

  // buffer needs no reset: only entries of the current record are read
  always_ff @(posedge clk) begin
    if (in_acc) begin
      bytes_r[fill_r[IDX_W-1:0]] <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      idx_r     <= '0;
      sum_r     <= 8'h00;
      addr_r    <= 16'h0000;
      start_r   <= 16'h0000;
      add_end_r <= 1'b1;
      last_r    <= 1'b0;
    end else begin
      fill_r    <= fill_nxt;
      idx_r     <= idx_nxt;
      sum_r     <= sum_nxt;
      addr_r    <= addr_nxt;
      start_r   <= start_nxt;
      add_end_r <= add_end_nxt;
      last_r    <= last_nxt;
    end
  end

endmodule

>>> rtl/intel_hex_record_encoder.sv
// Intel HEX record encoder: top level with output register.
// Depends on ihex_pkg, ihex_useq and ihex_dp.
//
// Usage:
//  - in_*: one data byte per item, in_tlast marks the final byte of a run.
//  - out_*: one ASCII character per item; out_tlast marks the last char
//    caused by an input byte (the newline of a data or end-of-file record).
//  - cfg_*: index 0 = start address (16 b), index 1 = append EOF record.
//    Always ready; write only while idle. Other indexes are ignored.
// Flow:
//  - A byte that neither fills the buffer nor is last is only stored.
//  - A record of n bytes: 12 + 2n chars, plus 12 for the EOF record.
//    The triggering byte starts the step counter; its first char then
//    goes into the output register, and one char per cycle follows
//    while out_tready is high (one microcode step per char).
//  - in_tready is low while the sequencer runs.
// Reset: buffer empty, address = 0, EOF record enabled, output empty.
// Stall: a low out_tready on a waiting char holds the output reg and step counter.
module intel_hex_record_encoder #(
  parameter int RECORD_BYTES = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] data_byte
  input  logic                           in_tlast,   // last_byte
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,  // [6:0] out_char, [7] zero
  output logic                           out_tlast,  // run_last
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ihex_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data
);
  import ihex_pkg::*;

  seq_st_t    seq_st;
  cfg_wr_t    cfg;
  logic       in_acc, start, adv;
  logic       rec_due, loop_more, eof_go;
  logic [6:0] ch;

  logic       out_valid_r, out_valid_nxt;
  logic [6:0] out_char_r, out_char_nxt;
  logic       out_last_r, out_last_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = '{vld: cfg_valid, idx: cfg_index, data: cfg_data};

  // no new bytes while a record is being emitted
  assign in_tready = !seq_st.busy;
  assign in_acc    = in_tvalid && in_tready;
  assign start     = in_acc && rec_due;

  // a step runs when the output register is free or being drained
  assign adv = seq_st.busy && (!out_valid_r || out_tready);

  ihex_useq u_useq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .adv       (adv),
    .loop_more (loop_more),
    .eof_go    (eof_go),
    .seq_st    (seq_st)
  );

  ihex_dp #(
    .RECORD_BYTES (RECORD_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_acc    (in_acc),
    .in_byte   (in_tdata),
    .in_last   (in_tlast),
    .cfg       (cfg),
    .adv       (adv),
    .seq_st    (seq_st),
    .rec_due   (rec_due),
    .loop_more (loop_more),
    .eof_go    (eof_go),
    .ch        (ch)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = ch;
      out_last_nxt  = seq_st.fin;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_char_r};
  assign out_tlast  = out_last_r;

endmodule

>>> rtl/ihex_chk.sv
// Port-level checker for the Intel HEX record encoder, with its bind.
// Depends on intel_hex_record_encoder_macros.svh.
`include "intel_hex_record_encoder_macros.svh"

module ihex_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       in_tlast,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic       cfg_ready
);

  // stalled char holds
  `IHEX_ASSERT_NEXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast))

  // a char flagged last is always a newline
  `IHEX_ASSERT_SAME(a_nl_last, out_tvalid && out_tlast, out_tdata == 8'h0A)

  // the last byte of a run always starts a record
  `IHEX_ASSERT_NEXT(a_last_busy, in_tvalid && in_tready && in_tlast, !in_tready)

  // output empty and inputs ready right after reset
  `IHEX_ASSERT_RST(a_rst, !rst_n, !out_tvalid && in_tready && cfg_ready)

endmodule

bind intel_hex_record_encoder ihex_chk u_ihex_chk (.*);
